### rtl/lstep_pkg.sv
// Shared types and constants for the two-axis line stepper with speed ramp.
// Used by the interfaces, the controller, the datapath and the top level.
`default_nettype none

package lstep_pkg;

  localparam int POS_W     = 24;
  localparam int SPEED_W   = 16;
  localparam int CFG_W     = 24;
  localparam int PERIOD_W  = 24;
  localparam int CFG_IDX_W = 1;
  localparam int DELTA_W   = POS_W + 1;
  localparam int ERR_W     = POS_W + 3;
  localparam int LEN_W     = DELTA_W;
  localparam int SQ_W      = 2 * SPEED_W;
  localparam int RAMP_W    = SQ_W;
  localparam int DIVN_W    = LEN_W + RAMP_W;
  localparam int DIVD_W    = RAMP_W + 1;
  localparam int RAD_W     = SQ_W + 2;

  localparam logic [CFG_W-1:0] RAMP_INC_RESET   = 24'd2000;
  localparam logic [CFG_W-1:0] TIMER_RATE_RESET = 24'd1000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAMP_INC   = 1'b0,
    REG_TIMER_RATE = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SQ_CRUISE,
    SQ_START,
    SQ_END,
    SQ_CUR
  } sq_sel_t;

  typedef enum logic [2:0] {
    DIV_ACC,
    DIV_DEC,
    DIV_SPLIT,
    DIV_PSTART,
    DIV_POF
  } div_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_CRUISE,
    ST_SQ_START,
    ST_SQ_END,
    ST_ACC,
    ST_ACC_WAIT,
    ST_DEC,
    ST_DEC_WAIT,
    ST_SPLIT_MUL,
    ST_SPLIT,
    ST_SPLIT_WAIT,
    ST_PER_START,
    ST_RAMP,
    ST_ROOT,
    ST_ROOT_WAIT,
    ST_PER_OF,
    ST_PER_WAIT,
    ST_OUT
  } lstep_state_t;

  typedef struct packed {
    logic     load_move;
    logic     tick_idle;
    logic     tick_finish;
    logic     tick_step;
    logic     sq_en;
    sq_sel_t  sq_sel;
    logic     div_start;
    div_sel_t div_sel;
    logic     split_mul;
    logic     root_start;
  } lstep_cmd_t;

  typedef struct packed {
    logic busy;
    logic at_end;
    logic need_split;
    logic ramp_up;
    logic ramp_down;
    logic div_done;
    logic root_done;
  } lstep_status_t;

endpackage

`default_nettype wire

### rtl/lstep_if.sv
// Handshake interfaces for the request (move or tick) and response channels.
// Depends on lstep_pkg for field widths.
`default_nettype none

interface lstep_req_if import lstep_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic signed [POS_W-1:0]    target_x;
  logic signed [POS_W-1:0]    target_y;
  logic        [SPEED_W-1:0]  cruise_speed;
  logic        [SPEED_W-1:0]  start_speed;
  logic        [SPEED_W-1:0]  end_speed;

  modport source (output valid, mode, target_x, target_y, cruise_speed, start_speed,
                  end_speed, input ready);
  modport sink   (input valid, mode, target_x, target_y, cruise_speed, start_speed,
                  end_speed, output ready);
endinterface

interface lstep_rsp_if import lstep_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic                       step_x;
  logic                       step_y;
  logic                       dir_x;
  logic                       dir_y;
  logic        [PERIOD_W-1:0] period;
  logic                       moving;
  logic signed [POS_W-1:0]    pos_x;
  logic signed [POS_W-1:0]    pos_y;

  modport source (output valid, step_x, step_y, dir_x, dir_y, period, moving, pos_x, pos_y,
                  input ready);
  modport sink   (input valid, step_x, step_y, dir_x, dir_y, period, moving, pos_x, pos_y,
                  output ready);
endinterface

`default_nettype wire

### rtl/lstep_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Standalone; instantiated by the datapath.
`default_nettype none

module lstep_div #(
  parameter int N = 57,
  parameter int D = 33
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);

  localparam int CNT_W = $clog2(N + 1);

  logic [D-1:0]     rem;
  logic [D-1:0]     dvs;
  logic [N-1:0]     quo;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [D:0]       shifted;
  logic [D:0]       diff;
  logic             take;

  assign shifted  = {rem, quo[N-1]};
  assign take     = shifted >= {1'b0, dvs};
  assign diff     = shifted - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(N);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (run) begin
      rem <= take ? diff[D-1:0] : shifted[D-1:0];
      quo <= {quo[N-2:0], take};
    end
  end

endmodule

`default_nettype wire

### rtl/lstep_sqrt.sv
// Iterative integer square root, one result bit per cycle (bit-pair method).
// Standalone; instantiated by the datapath. W must be even.
`default_nettype none

module lstep_sqrt #(
  parameter int W = 34
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   radicand,
  output logic           done,
  output logic [W/2-1:0] root
);

  logic [W-1:0] v;
  logic [W-1:0] r;
  logic [W-1:0] bitq;
  logic [W-1:0] sum;
  logic         run;
  logic         ge;

  assign sum  = r + bitq;
  assign ge   = v >= sum;
  assign root = r[W/2-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && bitq[0]) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= radicand;
      r    <= '0;
      bitq <= {2'b01, {(W-2){1'b0}}};
    end else if (run) begin
      if (ge) begin
        v <= v - sum;
        r <= (r >> 1) + bitq;
      end else begin
        r <= r >> 1;
      end
      bitq <= bitq >> 2;
    end
  end

endmodule

`default_nettype wire

### rtl/lstep_dp.sv
// Datapath: position and line state, ramp planning, speed update and period.
// Depends on lstep_pkg, lstep_div and lstep_sqrt; driven by lstep_ctrl.
`default_nettype none

module lstep_dp import lstep_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic signed [POS_W-1:0]    target_x,
  input  logic signed [POS_W-1:0]    target_y,
  input  logic [SPEED_W-1:0]         cruise_speed,
  input  logic [SPEED_W-1:0]         start_speed,
  input  logic [SPEED_W-1:0]         end_speed,
  input  lstep_cmd_t                 cmd,
  output lstep_status_t              status,
  output logic                       step_x,
  output logic                       step_y,
  output logic                       dir_x,
  output logic                       dir_y,
  output logic [PERIOD_W-1:0]        period,
  output logic                       moving,
  output logic signed [POS_W-1:0]    pos_x,
  output logic signed [POS_W-1:0]    pos_y
);

  logic [CFG_W-1:0]        ramp_inc;
  logic [CFG_W-1:0]        timer_rate;
  logic signed [POS_W-1:0] position_x;
  logic signed [POS_W-1:0] position_y;
  logic [DELTA_W-1:0]      delta_x;
  logic [DELTA_W-1:0]      delta_y;
  logic                    sign_x;
  logic                    sign_y;
  logic signed [ERR_W-1:0] line_error;
  logic [LEN_W-1:0]        move_length;
  logic [LEN_W-1:0]        steps_done;
  logic [RAMP_W-1:0]       accel_len;
  logic [RAMP_W-1:0]       decel_len;
  logic [SPEED_W-1:0]      current_speed;
  logic [SPEED_W-1:0]      speed_cruise;
  logic [SPEED_W-1:0]      speed_start;
  logic [SPEED_W-1:0]      speed_end;
  logic                    busy;
  logic                    step_x_q;
  logic                    step_y_q;
  logic [PERIOD_W-1:0]     period_q;
  logic [SQ_W-1:0]         sq_a;
  logic [SQ_W-1:0]         sq_b;
  logic [SQ_W-1:0]         sq_c;
  logic [DIVN_W-1:0]       prod;
  div_sel_t                div_sel_q;
  logic                    root_up_q;

  // Move planning.
  logic signed [DELTA_W-1:0] diff_x;
  logic signed [DELTA_W-1:0] diff_y;
  logic [DELTA_W-1:0]        abs_x;
  logic [DELTA_W-1:0]        abs_y;
  logic [LEN_W-1:0]          len_init;
  logic signed [ERR_W-1:0]   err_init;

  assign diff_x   = $signed({target_x[POS_W-1], target_x}) -
                    $signed({position_x[POS_W-1], position_x});
  assign diff_y   = $signed({target_y[POS_W-1], target_y}) -
                    $signed({position_y[POS_W-1], position_y});
  assign abs_x    = diff_x[DELTA_W-1] ? DELTA_W'(-diff_x) : DELTA_W'(diff_x);
  assign abs_y    = diff_y[DELTA_W-1] ? DELTA_W'(-diff_y) : DELTA_W'(diff_y);
  assign len_init = (abs_x >= abs_y) ? abs_x : abs_y;
  assign err_init = $signed(ERR_W'(abs_x)) - $signed(ERR_W'(abs_y));

  // Shared squaring multiplier.
  logic [SPEED_W-1:0] sq_op;
  logic [SQ_W-1:0]    sq_prod;

  always_comb begin
    case (cmd.sq_sel)
      SQ_CRUISE: sq_op = speed_cruise;
      SQ_START:  sq_op = speed_start;
      SQ_END:    sq_op = speed_end;
      default:   sq_op = current_speed;
    endcase
  end

  assign sq_prod = sq_op * sq_op;

  // Divider operands.
  logic [CFG_W-1:0]   inc_nz;
  logic [SQ_W-1:0]    acc_num;
  logic [SQ_W-1:0]    dec_num;
  logic [DIVD_W-1:0]  ramp_sum;
  logic [SPEED_W-1:0] lo_speed;
  logic [SPEED_W-1:0] clamp_speed;
  logic [SPEED_W-1:0] pof_div;
  logic [SPEED_W-1:0] pstart_div;
  logic [DIVN_W-1:0]  div_n;
  logic [DIVD_W-1:0]  div_d;
  logic               div_done;
  logic [DIVN_W-1:0]  div_q;

  assign inc_nz   = (ramp_inc == '0) ? CFG_W'(1) : ramp_inc;
  assign acc_num  = (sq_a > sq_b) ? (sq_a - sq_b) : '0;
  assign dec_num  = (sq_a > sq_c) ? (sq_a - sq_c) : '0;
  assign ramp_sum = {1'b0, accel_len} + {1'b0, decel_len};
  assign lo_speed = (speed_start < speed_end) ? speed_start : speed_end;

  always_comb begin
    if (current_speed < lo_speed) begin
      clamp_speed = lo_speed;
    end else if (current_speed > speed_cruise) begin
      clamp_speed = speed_cruise;
    end else begin
      clamp_speed = current_speed;
    end
  end

  assign pof_div    = (clamp_speed == '0) ? SPEED_W'(1) : clamp_speed;
  assign pstart_div = (current_speed == '0) ? SPEED_W'(1) : current_speed;

  always_comb begin
    case (cmd.div_sel)
      DIV_ACC: begin
        div_n = DIVN_W'(acc_num);
        div_d = DIVD_W'(inc_nz);
      end
      DIV_DEC: begin
        div_n = DIVN_W'(dec_num);
        div_d = DIVD_W'(inc_nz);
      end
      DIV_SPLIT: begin
        div_n = prod;
        div_d = ramp_sum;
      end
      DIV_PSTART: begin
        div_n = DIVN_W'(timer_rate);
        div_d = DIVD_W'(pstart_div);
      end
      default: begin
        div_n = DIVN_W'(timer_rate);
        div_d = DIVD_W'(pof_div);
      end
    endcase
  end

  lstep_div #(
    .N(DIVN_W),
    .D(DIVD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // Square root for the speed ramp.
  logic [RAD_W-1:0]   rad;
  logic               root_done;
  logic [RAD_W/2-1:0] root;
  logic [RAD_W/2-1:0] root_floor;
  logic [RAD_W/2-1:0] root_cl;
  logic [SPEED_W-1:0] root_speed;

  always_comb begin
    if (status.ramp_up) begin
      rad = RAD_W'(sq_a) + RAD_W'(ramp_inc);
    end else if (sq_a >= SQ_W'(ramp_inc)) begin
      rad = RAD_W'(sq_a - SQ_W'(ramp_inc));
    end else begin
      rad = '0;
    end
  end

  lstep_sqrt #(
    .W(RAD_W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.root_start),
    .radicand (rad),
    .done     (root_done),
    .root     (root)
  );

  assign root_floor = {1'b0, (root_up_q ? speed_start : speed_end)};
  assign root_cl    = (root < root_floor) ? root_floor : root;
  assign root_speed = root_cl[RAD_W/2-1] ? '1 : root_cl[SPEED_W-1:0];

  // One Bresenham step.
  logic signed [ERR_W:0]   e2;
  logic signed [ERR_W-1:0] dx_e;
  logic signed [ERR_W-1:0] dy_e;
  logic                    take_x;
  logic                    take_y;
  logic signed [ERR_W-1:0] err_step;

  assign e2       = {line_error, 1'b0};
  assign dx_e     = $signed(ERR_W'(delta_x));
  assign dy_e     = $signed(ERR_W'(delta_y));
  assign take_x   = e2 > -$signed((ERR_W+1)'(delta_y));
  assign take_y   = e2 < $signed((ERR_W+1)'(delta_x));
  assign err_step = line_error - (take_x ? dy_e : ERR_W'(0)) + (take_y ? dx_e : ERR_W'(0));

  // Status towards the controller.
  logic signed [RAMP_W+1:0] down_lim;

  assign down_lim = $signed((RAMP_W+2)'(move_length)) - $signed((RAMP_W+2)'(decel_len));

  always_comb begin
    status.busy       = busy;
    status.at_end     = steps_done == move_length;
    status.need_split = (DIVD_W'(move_length) < ramp_sum) && (accel_len != '0) &&
                        (decel_len != '0);
    status.ramp_up    = RAMP_W'(steps_done) < accel_len;
    status.ramp_down  = $signed((RAMP_W+2)'(steps_done)) > down_lim;
    status.div_done   = div_done;
    status.root_done  = root_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_inc      <= RAMP_INC_RESET;
      timer_rate    <= TIMER_RATE_RESET;
      position_x    <= '0;
      position_y    <= '0;
      delta_x       <= '0;
      delta_y       <= '0;
      sign_x        <= 1'b0;
      sign_y        <= 1'b0;
      line_error    <= '0;
      move_length   <= '0;
      steps_done    <= '0;
      accel_len     <= '0;
      decel_len     <= '0;
      current_speed <= '0;
      speed_cruise  <= '0;
      speed_start   <= '0;
      speed_end     <= '0;
      busy          <= 1'b0;
      step_x_q      <= 1'b0;
      step_y_q      <= 1'b0;
      period_q      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RAMP_INC:   ramp_inc   <= cfg_data;
          REG_TIMER_RATE: timer_rate <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load_move) begin
        speed_cruise  <= cruise_speed;
        speed_start   <= start_speed;
        speed_end     <= end_speed;
        delta_x       <= abs_x;
        delta_y       <= abs_y;
        sign_x        <= !diff_x[DELTA_W-1] && (diff_x != '0);
        sign_y        <= !diff_y[DELTA_W-1] && (diff_y != '0);
        line_error    <= err_init;
        move_length   <= len_init;
        steps_done    <= '0;
        current_speed <= start_speed;
        busy          <= 1'b1;
        step_x_q      <= 1'b0;
        step_y_q      <= 1'b0;
      end
      if (cmd.tick_idle) begin
        step_x_q <= 1'b0;
        step_y_q <= 1'b0;
        period_q <= '0;
      end
      if (cmd.tick_finish) begin
        busy          <= 1'b0;
        delta_x       <= '0;
        delta_y       <= '0;
        line_error    <= '0;
        move_length   <= '0;
        steps_done    <= '0;
        accel_len     <= '0;
        decel_len     <= '0;
        current_speed <= '0;
        step_x_q      <= 1'b0;
        step_y_q      <= 1'b0;
        period_q      <= '0;
      end
      if (cmd.tick_step) begin
        line_error <= err_step;
        step_x_q   <= take_x;
        step_y_q   <= take_y;
        steps_done <= steps_done + 1'b1;
        if (take_x) begin
          position_x <= position_x + (sign_x ? POS_W'(1) : '1);
        end
        if (take_y) begin
          position_y <= position_y + (sign_y ? POS_W'(1) : '1);
        end
      end
      if (div_done) begin
        case (div_sel_q)
          DIV_ACC:   accel_len <= div_q[RAMP_W-1:0];
          DIV_DEC:   decel_len <= div_q[RAMP_W-1:0];
          DIV_SPLIT: begin
            accel_len <= RAMP_W'(div_q[LEN_W-1:0]);
            decel_len <= RAMP_W'(move_length - div_q[LEN_W-1:0]);
          end
          default:   period_q <= div_q[PERIOD_W-1:0];
        endcase
      end
      if (root_done) begin
        current_speed <= root_speed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_en) begin
      case (cmd.sq_sel)
        SQ_START: sq_b <= sq_prod;
        SQ_END:   sq_c <= sq_prod;
        default:  sq_a <= sq_prod;
      endcase
    end
    if (cmd.split_mul) begin
      prod <= DIVN_W'(move_length) * DIVN_W'(accel_len);
    end
    if (cmd.div_start) begin
      div_sel_q <= cmd.div_sel;
    end
    if (cmd.root_start) begin
      root_up_q <= status.ramp_up;
    end
  end

  assign step_x = step_x_q;
  assign step_y = step_y_q;
  assign dir_x  = sign_x;
  assign dir_y  = sign_y;
  assign period = period_q;
  assign moving = busy;
  assign pos_x  = position_x;
  assign pos_y  = position_y;

endmodule

`default_nettype wire

### rtl/lstep_ctrl.sv
// Controller state machine: sequences move planning and tick processing.
// Depends on lstep_pkg; drives lstep_dp through the command struct.
`default_nettype none

module lstep_ctrl import lstep_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_mode,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  lstep_status_t status,
  output lstep_cmd_t    cmd
);

  lstep_state_t state;
  lstep_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (!in_mode) begin
            state_next = ST_SQ_CRUISE;
          end else if (status.busy && !status.at_end) begin
            state_next = ST_RAMP;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_SQ_CRUISE:  state_next = ST_SQ_START;
      ST_SQ_START:   state_next = ST_SQ_END;
      ST_SQ_END:     state_next = ST_ACC;
      ST_ACC:        state_next = ST_ACC_WAIT;
      ST_ACC_WAIT:   if (status.div_done) state_next = ST_DEC;
      ST_DEC:        state_next = ST_DEC_WAIT;
      ST_DEC_WAIT:   if (status.div_done) state_next = ST_SPLIT_MUL;
      // The deceleration length is only registered once the divider is done,
      // so the overlap test is made in the cycle after it.
      ST_SPLIT_MUL:  state_next = status.need_split ? ST_SPLIT : ST_PER_START;
      ST_SPLIT:      state_next = ST_SPLIT_WAIT;
      ST_SPLIT_WAIT: if (status.div_done) state_next = ST_PER_START;
      ST_PER_START:  state_next = ST_PER_WAIT;
      ST_RAMP: begin
        state_next = (status.ramp_up || status.ramp_down) ? ST_ROOT : ST_PER_OF;
      end
      ST_ROOT:       state_next = ST_ROOT_WAIT;
      ST_ROOT_WAIT:  if (status.root_done) state_next = ST_PER_OF;
      ST_PER_OF:     state_next = ST_PER_WAIT;
      ST_PER_WAIT:   if (status.div_done) state_next = ST_OUT;
      ST_OUT:        if (out_ready) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = state == ST_IDLE;
    out_valid = state == ST_OUT;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (!in_mode) begin
            cmd.load_move = 1'b1;
          end else if (!status.busy) begin
            cmd.tick_idle = 1'b1;
          end else if (status.at_end) begin
            cmd.tick_finish = 1'b1;
          end else begin
            cmd.tick_step = 1'b1;
          end
        end
      end
      ST_SQ_CRUISE: begin
        cmd.sq_en  = 1'b1;
        cmd.sq_sel = SQ_CRUISE;
      end
      ST_SQ_START: begin
        cmd.sq_en  = 1'b1;
        cmd.sq_sel = SQ_START;
      end
      ST_SQ_END: begin
        cmd.sq_en  = 1'b1;
        cmd.sq_sel = SQ_END;
      end
      ST_ACC: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_ACC;
      end
      ST_DEC: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_DEC;
      end
      ST_SPLIT_MUL: cmd.split_mul = 1'b1;
      ST_SPLIT: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SPLIT;
      end
      ST_PER_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_PSTART;
      end
      ST_RAMP: begin
        cmd.sq_en  = 1'b1;
        cmd.sq_sel = SQ_CUR;
      end
      ST_ROOT: cmd.root_start = 1'b1;
      ST_PER_OF: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_POF;
      end
      default: ;
    endcase
  end

  // A tick taken while no move runs is answered on the very next cycle.
  a_idle_tick_fast: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_mode && !status.busy) |=> out_valid)
    else $error("idle tick not answered at once");

  a_move_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !in_mode) |=> status.busy)
    else $error("move item did not start a move");

  a_root_needs_ramp: assert property (@(posedge clk) disable iff (rst)
    cmd.root_start |-> (status.ramp_up || status.ramp_down))
    else $error("square root started outside a ramp");

  a_div_done_waiting: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == ST_ACC_WAIT || state == ST_DEC_WAIT ||
                         state == ST_SPLIT_WAIT || state == ST_PER_WAIT))
    else $error("divider finished while nothing waited for it");

endmodule

`default_nettype wire

### rtl/two_axis_line_stepper_with_ramp_unit.sv
// Two-axis line stepper with trapezoid speed ramp. One item is handled at a
// time and each gives one response item. A move item squares the three
// speeds and then runs the shared 57-step divider three or four times (ramp
// lengths, the proportional split when the ramps overlap, start period).
// A tick that steps runs the 17-step square root on ramp steps and one
// division for the period; a tick when idle or finishing needs neither.
// Configuration writes are taken in any cycle but belong to idle periods.
`default_nettype none

module two_axis_line_stepper_with_ramp_unit import lstep_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  lstep_req_if.sink            req,
  lstep_rsp_if.source          rsp
);

  lstep_cmd_t    cmd;
  lstep_status_t status;

  lstep_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_mode   (req.mode),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lstep_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .target_x     (req.target_x),
    .target_y     (req.target_y),
    .cruise_speed (req.cruise_speed),
    .start_speed  (req.start_speed),
    .end_speed    (req.end_speed),
    .cmd          (cmd),
    .status       (status),
    .step_x       (rsp.step_x),
    .step_y       (rsp.step_y),
    .dir_x        (rsp.dir_x),
    .dir_y        (rsp.dir_y),
    .period       (rsp.period),
    .moving       (rsp.moving),
    .pos_x        (rsp.pos_x),
    .pos_y        (rsp.pos_y)
  );

endmodule

`default_nettype wire

### bench/tb_two_axis_line_stepper_with_ramp_unit.sv
// Self-checking testbench for the two-axis line stepper with speed ramp.
// Drives move and tick items against its own model of the stepper and ramp.
// Depends on lstep_pkg, lstep_if.sv and the top level of the block.
`timescale 1ns / 1ps

module tb_two_axis_line_stepper_with_ramp_unit;
  import lstep_pkg::*;

  localparam bit MODE_MOVE = 1'b0;
  localparam bit MODE_TICK = 1'b1;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SPEED_MAX = 65535;

  typedef struct {
    bit             sx, sy, dx, dy;
    bit [23:0]      period;
    bit             moving;
    bit [23:0]      px, py;
  } step_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  lstep_req_if req ();
  lstep_rsp_if rsp ();

  two_axis_line_stepper_with_ramp_unit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Model state of the stepper.
  longint unsigned ramp_inc_m, timer_rate_m;
  longint cur_x, cur_y, dlt_x, dlt_y, line_err, len_m, done_m, acc_len, dec_len;
  bit dir_xs, dir_ys, busy_m;
  longint unsigned speed_m, spd_cruise, spd_start, spd_end;

  step_result_t pending_results[$];
  int errors = 0;
  int items_sent = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  function automatic longint wrap_pos(longint v);
    logic signed [23:0] t;
    t = v[23:0];
    return t;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned ramp_steps(longint unsigned top, longint unsigned from);
    longint unsigned inc;
    inc = ramp_inc_m != 0 ? ramp_inc_m : 1;
    if (from * from >= top * top) return 0;
    return (top * top - from * from) / inc;
  endfunction

  function automatic longint unsigned period_for(longint unsigned s);
    longint unsigned lo;
    lo = spd_start < spd_end ? spd_start : spd_end;
    if (s < lo) s = lo;
    else if (s > spd_cruise) s = spd_cruise;
    if (s == 0) s = 1;
    return (timer_rate_m / s) & 24'hFFFFFF;
  endfunction

  function automatic step_result_t predict_step(bit mode, logic signed [23:0] tx_in,
                                                logic signed [23:0] ty_in,
                                                logic [15:0] cruise, logic [15:0] start,
                                                logic [15:0] stop);
    step_result_t r;
    longint tx, ty, e2;
    longint unsigned acc, dec, d, s, sq;
    r = '{default: 0};
    if (mode == MODE_MOVE) begin
      tx = tx_in;
      ty = ty_in;
      spd_cruise = cruise;
      spd_start = start;
      spd_end = stop;
      dlt_x = tx > cur_x ? tx - cur_x : cur_x - tx;
      dlt_y = ty > cur_y ? ty - cur_y : cur_y - ty;
      dir_xs = cur_x < tx;
      dir_ys = cur_y < ty;
      line_err = dlt_x - dlt_y;
      len_m = dlt_x >= dlt_y ? dlt_x : dlt_y;
      done_m = 0;
      acc = ramp_steps(spd_cruise, spd_start);
      dec = ramp_steps(spd_cruise, spd_end);
      // Overlapping ramps share the distance in proportion to their lengths.
      if (longint'(len_m) < acc + dec && acc != 0 && dec != 0) begin
        acc = longint'(len_m) * acc / (acc + dec);
        dec = len_m - acc;
      end
      acc_len = acc;
      dec_len = dec;
      speed_m = spd_start;
      busy_m = 1;
      d = speed_m != 0 ? speed_m : 1;
      r.period = (timer_rate_m / d) & 24'hFFFFFF;
    end else if (busy_m) begin
      if (done_m == len_m) begin
        busy_m = 0;
        dlt_x = 0; dlt_y = 0; line_err = 0; len_m = 0; done_m = 0;
        acc_len = 0; dec_len = 0; speed_m = 0;
      end else begin
        e2 = line_err * 2;
        if (e2 > -dlt_y) begin
          line_err -= dlt_y;
          cur_x = wrap_pos(cur_x + (dir_xs ? 1 : -1));
          r.sx = 1;
        end
        if (e2 < dlt_x) begin
          line_err += dlt_x;
          cur_y = wrap_pos(cur_y + (dir_ys ? 1 : -1));
          r.sy = 1;
        end
        done_m++;
        if (done_m < acc_len) begin
          s = int_sqrt(speed_m * speed_m + ramp_inc_m);
          if (s < spd_start) s = spd_start;
          speed_m = s > SPEED_MAX ? SPEED_MAX : s;
        end else if (done_m > len_m - dec_len) begin
          // A radicand below zero gives a root of zero.
          sq = speed_m * speed_m;
          s = sq >= ramp_inc_m ? int_sqrt(sq - ramp_inc_m) : 0;
          if (s < spd_end) s = spd_end;
          speed_m = s > SPEED_MAX ? SPEED_MAX : s;
        end
        r.period = period_for(speed_m);
      end
    end
    r.dx = dir_xs;
    r.dy = dir_ys;
    r.moving = busy_m;
    r.px = cur_x[23:0];
    r.py = cur_y[23:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch in %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  task automatic send_item(bit mode, logic signed [23:0] tx, logic signed [23:0] ty,
                           logic [15:0] cruise, logic [15:0] start, logic [15:0] stop);
    if (!quiet && $urandom_range(0, 99) < 26) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.mode <= mode;
    req.target_x <= tx;
    req.target_y <= ty;
    req.cruise_speed <= cruise;
    req.start_speed <= start;
    req.end_speed <= stop;
    do @(posedge clk); while (!req.ready);
    pending_results.push_back(predict_step(mode, tx, ty, cruise, start, stop));
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(MODE_TICK, 24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom));
  endtask

  // Move relative to the modelled position, then tick to the end of the move.
  task automatic run_move(int dx, int dy, int cruise, int start, int stop, int extra);
    longint n;
    send_item(MODE_MOVE, 24'(cur_x + dx), 24'(cur_y + dy), 16'(cruise), 16'(start),
              16'(stop));
    n = len_m + 1 + extra;
    repeat (n) send_tick();
  endtask

  task automatic wait_idle();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 24'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_RAMP_INC) ramp_inc_m = value & 24'hFFFFFF;
    else timer_rate_m = value & 24'hFFFFFF;
  endtask

  task automatic test_directed();
    send_tick();
    run_move(0, 0, 500, 100, 100, 1);
    send_item(MODE_MOVE, 24'sh7FFFFF, -24'sh800000, 16'hFFFF, 16'd1, 16'd1);
    repeat (3) send_tick();
    // Short line with overlapping ramps, then start and end above cruise.
    run_move(7, 3, 1000, 1, 1, 0);
    run_move(-2, -5, 100, 65535, 65535, 0);
  endtask

  function automatic int pick_speed();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 3000);
  endfunction

  task automatic test_random(int count);
    int stop_at, kind;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        run_move($urandom_range(0, 80) - 40, $urandom_range(0, 80) - 40, pick_speed(),
                 pick_speed(), pick_speed(), $urandom_range(0, 2));
      end else if (kind == 8) begin
        // A far target is left unfinished by the next move.
        send_item(MODE_MOVE, 24'($urandom), 24'($urandom), 16'($urandom_range(1, 65535)),
                  16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
        repeat ($urandom_range(0, 5)) send_tick();
      end else begin
        repeat ($urandom_range(1, 3)) send_tick();
      end
    end
  endtask

  task automatic test_config_sweep();
    write_reg(REG_RAMP_INC, 1);
    write_reg(REG_TIMER_RATE, 24'hFFFFFF);
    quiet = 1'b1;
    test_random(260);
    quiet = 1'b0;
    write_reg(REG_RAMP_INC, 24'hFFFFFF);
    write_reg(REG_TIMER_RATE, 1);
    test_random(260);
    write_reg(REG_RAMP_INC, $urandom_range(1, 50000));
    write_reg(REG_TIMER_RATE, $urandom_range(1, 24'hFFFFFF));
    test_random(250);
  endtask

  always @(posedge clk) begin
    step_result_t w;
    if (rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $display("result item arrived with none expected");
        errors++;
      end else begin
        w = pending_results.pop_front();
        if (rsp.step_x !== w.sx) report_mismatch("step_x", rsp.step_x, w.sx);
        if (rsp.step_y !== w.sy) report_mismatch("step_y", rsp.step_y, w.sy);
        if (rsp.dir_x !== w.dx) report_mismatch("dir_x", rsp.dir_x, w.dx);
        if (rsp.dir_y !== w.dy) report_mismatch("dir_y", rsp.dir_y, w.dy);
        if (rsp.period !== w.period) report_mismatch("period", rsp.period, w.period);
        if (rsp.moving !== w.moving) report_mismatch("moving", rsp.moving, w.moving);
        if (rsp.pos_x !== w.px) report_mismatch("pos_x", rsp.pos_x, w.px);
        if (rsp.pos_y !== w.py) report_mismatch("pos_y", rsp.pos_y, w.py);
      end
    end
    if (rst) rsp.ready <= 1'b0;
    else rsp.ready <= quiet || $urandom_range(0, 99) >= 26;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_two_axis_line_stepper_with_ramp_unit failed");
      $finish;
    end
  end

  initial begin
    req.valid = 1'b0;
    req.mode = MODE_TICK;
    req.target_x = '0;
    req.target_y = '0;
    req.cruise_speed = '0;
    req.start_speed = '0;
    req.end_speed = '0;
    rsp.ready = 1'b0;
    ramp_inc_m = 2000;
    timer_rate_m = 1000000;
    cur_x = 0; cur_y = 0; dlt_x = 0; dlt_y = 0; line_err = 0; len_m = 0; done_m = 0;
    acc_len = 0; dec_len = 0; dir_xs = 0; dir_ys = 0; busy_m = 0;
    speed_m = 0; spd_cruise = 0; spd_start = 0; spd_end = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(260);
    test_config_sweep();
    wait_idle();
    if (errors == 0) begin
      $display("tb_two_axis_line_stepper_with_ramp_unit passed");
    end else begin
      $display("tb_two_axis_line_stepper_with_ramp_unit failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/lstep_pkg.sv
rtl/lstep_if.sv
rtl/lstep_div.sv
rtl/lstep_sqrt.sv
rtl/lstep_dp.sv
rtl/lstep_ctrl.sv
rtl/two_axis_line_stepper_with_ramp_unit.sv
bench/tb_two_axis_line_stepper_with_ramp_unit.sv
